@@ rtl/mtf_pkg.sv @@
package mtf_pkg;

  localparam int MAX_SYMBOLS_DEF = 256;
  localparam int SYM_W = 9;
  localparam int POS_W = 8;
  localparam int LSIZE_W = 9;
  localparam logic [LSIZE_W-1:0] LSIZE_RESET = 9'd256;
  localparam int GROUP_SIZE = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_RED1,
    ST_RED2,
    ST_DONE
  } mtf_state_e;

  typedef struct packed {
    logic load;    // back to ascending order
    logic cmp;     // capture compare result
    logic hit_en;  // symbol is in range, compare may hit
    logic shift;   // move to front
  } cell_ctl_t;

endpackage

@@ rtl/mtf_if.sv @@
interface mtf_sym_if import mtf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;

  modport source (output valid, output symbol, input ready);
  modport sink (input valid, input symbol, output ready);
endinterface

interface mtf_res_if import mtf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] position;
  logic             bad_symbol;

  modport source (output valid, output position, output bad_symbol, input ready);
  modport sink (input valid, input position, input bad_symbol, output ready);
endinterface

@@ rtl/move_to_front_encoder.sv @@
// channel   modport  payload               direction
// sym_i     sink     symbol[8:0]           in
// res_o     source   position[7:0], bad    out
// cfg       we/wdata list_size[8:0]        in
//
// one item at a time, in steps: accept, cell compare, two levels of the registered
// position tree, then the move to front together with loading the result register
// a new item is accepted while an earlier result still waits in the result register
// a held result stalls only the final step; reset restores ascending order and
// list_size 256, any list_size write restores ascending order
module move_to_front_encoder import mtf_pkg::*; #(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  mtf_sym_if.sink            sym_i,
  mtf_res_if.source          res_o,
  input  logic               cfg_we_i,
  input  logic [LSIZE_W-1:0] cfg_wdata_i
);

  localparam int EW = $clog2(MAX_SYMBOLS + 1);
  localparam int PW = $clog2(MAX_SYMBOLS);

  mtf_state_e         state_q, state_d;
  logic [LSIZE_W-1:0] lsize_q;
  logic [SYM_W-1:0]   sym_q;
  logic               bad_q;
  logic               res_valid_q, res_valid_d;
  logic [POS_W-1:0]   res_pos_q;
  logic               res_bad_q;

  logic               accept;
  logic               advance;
  logic               in_range;
  logic               item_bad;
  logic [31:0]        pos_ext;
  cell_ctl_t          ctl;
  logic [EW-1:0]      sym_e;
  logic [PW-1:0]      pos;
  logic               found;
  logic [EW-1:0]      vals [MAX_SYMBOLS];
  logic [MAX_SYMBOLS-1:0] match;

  assign accept   = sym_i.valid && sym_i.ready;
  assign in_range = (sym_i.symbol != '0) && (sym_i.symbol <= lsize_q)
                    && (32'(sym_i.symbol) <= MAX_SYMBOLS);
  assign advance  = !res_valid_q || res_o.ready;
  assign item_bad = bad_q || !found;
  assign pos_ext  = 32'(pos);
  assign sym_e    = EW'(sym_q);

  always_comb begin
    state_d      = state_q;
    res_valid_d  = res_valid_q && !res_o.ready;
    sym_i.ready  = 1'b0;
    ctl.load     = cfg_we_i;
    ctl.cmp      = 1'b0;
    ctl.hit_en   = !bad_q;
    ctl.shift    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        sym_i.ready = 1'b1;
        if (sym_i.valid) state_d = ST_CMP;
      end
      ST_CMP: begin
        ctl.cmp = 1'b1;
        state_d = ST_RED1;
      end
      ST_RED1: state_d = ST_RED2;
      ST_RED2: state_d = ST_DONE;
      ST_DONE: begin
        if (advance) begin
          ctl.shift   = !item_bad;
          res_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lsize_q     <= LSIZE_RESET;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) lsize_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sym_q <= sym_i.symbol;
      bad_q <= !in_range;
    end
    if (state_q == ST_DONE && advance) begin
      res_pos_q <= item_bad ? '0 : pos_ext[POS_W-1:0];
      res_bad_q <= item_bad;
    end
  end

  for (genvar k = 0; k < MAX_SYMBOLS; k++) begin : g_cell
    logic [EW-1:0] prev;
    if (k == 0) begin : g_head
      assign prev = sym_e;
    end else begin : g_body
      assign prev = vals[k-1];
    end
    mtf_cell #(.IDX(k), .EW(EW), .PW(PW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .sym_i   (sym_e),
      .pos_i   (pos),
      .prev_i  (prev),
      .val_o   (vals[k]),
      .match_o (match[k])
    );
  end

  mtf_reduce #(.N(MAX_SYMBOLS), .PW(PW)) u_reduce (
    .clk_i   (clk_i),
    .match_i (match),
    .pos_o   (pos),
    .found_o (found)
  );

  assign res_o.valid      = res_valid_q;
  assign res_o.position   = res_pos_q;
  assign res_o.bad_symbol = res_bad_q;

`ifndef SYNTH
  // the list is a permutation, so at most one cell can hit
  a_match_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("more than one cell matched");

  // an in-range symbol is always found in the list
  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !bad_q) |-> found)
    else $error("in-range symbol not found");

  // after a move the symbol sits at the front
  a_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.shift && !cfg_we_i) |=> (vals[0] == $past(sym_e)))
    else $error("moved symbol not at the front");

  // a list_size write restores ascending order
  a_cfg_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (vals[0] == EW'(1)))
    else $error("list not reset by list_size write");
`endif

endmodule

@@ rtl/mtf_cell.sv @@
module mtf_cell import mtf_pkg::*; #(
  parameter int IDX = 0,
  parameter int EW  = 9,
  parameter int PW  = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cell_ctl_t     ctl_i,
  input  logic [EW-1:0] sym_i,
  input  logic [PW-1:0] pos_i,
  input  logic [EW-1:0] prev_i,
  output logic [EW-1:0] val_o,
  output logic          match_o
);

  logic [EW-1:0] val_q, val_d;
  logic          match_q, match_d;

  always_comb begin
    val_d   = val_q;
    match_d = match_q;
    if (ctl_i.load) begin
      val_d = EW'(IDX + 1);
    end else if (ctl_i.shift && (PW'(IDX) <= pos_i)) begin
      val_d = prev_i;
    end
    if (ctl_i.cmp) begin
      match_d = ctl_i.hit_en && (val_q == sym_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q   <= EW'(IDX + 1);
      match_q <= 1'b0;
    end else begin
      val_q   <= val_d;
      match_q <= match_d;
    end
  end

  assign val_o   = val_q;
  assign match_o = match_q;

endmodule

@@ rtl/mtf_reduce.sv @@
module mtf_reduce import mtf_pkg::*; #(
  parameter int N  = 256,
  parameter int PW = 8
) (
  input  logic          clk_i,
  input  logic [N-1:0]  match_i,
  output logic [PW-1:0] pos_o,
  output logic          found_o
);

  localparam int NG = (N + GROUP_SIZE - 1) / GROUP_SIZE;

  logic [PW-1:0] grp_pos_q [NG];
  logic [PW-1:0] grp_pos_d [NG];
  logic [NG-1:0] grp_hit_q, grp_hit_d;
  logic [PW-1:0] pos_q, pos_d;
  logic          found_q, found_d;

  // at most one cell matches, so an or of the hit indexes is the position
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_pos_d[g] = '0;
      grp_hit_d[g] = 1'b0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        if (g * GROUP_SIZE + j < N) begin
          if (match_i[g * GROUP_SIZE + j]) begin
            grp_pos_d[g] = grp_pos_d[g] | PW'(g * GROUP_SIZE + j);
            grp_hit_d[g] = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    pos_d   = '0;
    found_d = |grp_hit_q;
    for (int g = 0; g < NG; g++) begin
      pos_d = pos_d | grp_pos_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    grp_pos_q <= grp_pos_d;
    grp_hit_q <= grp_hit_d;
    pos_q     <= pos_d;
    found_q   <= found_d;
  end

  assign pos_o   = pos_q;
  assign found_o = found_q;

endmodule
